// File: sv/rbpt_pkg.sv
// Shared constants and operation codes for the ring buffer pointer tracker.
`timescale 1ns / 1ps
`default_nettype none

package rbpt_pkg;

    // Largest buffer size the tracker is built for
    localparam int unsigned RBPT_MAX_SIZE = 4096;

    // Buffer size after reset, before clamping to the build maximum
    localparam int unsigned RBPT_RESET_SIZE = 4096;

    // Operation codes of a request; unknown codes behave as a query
    typedef enum logic [2:0] {
        OP_SUPPLY     = 3'd0,
        OP_CONSUME    = 3'd1,
        OP_SET_MARK   = 3'd2,
        OP_CLEAR_MARK = 3'd3,
        OP_QUERY      = 3'd4
    } t_op;

endpackage

`default_nettype wire

// File: sv/ring_buffer_pointer_tracker_with_mark.sv
// Write/read offset tracker for a circular byte buffer with an urgent mark.
//
// Usage:
//   A request (operation, byte count) is taken at a rising edge where start is
//   high and busy is low. busy never rises: a request may be given every cycle.
//   Each request yields exactly one result, shown for a single cycle with
//   o_done high: free and readable totals and runs, the mark flag, both
//   offsets and a reject flag for an oversized supply or consume.
//   The request register loads at the accepting edge, and the update logic
//   then fills the result register, where o_done rises; the receiver takes
//   the result from there.
//   Throughput is one request per cycle, set by the single update stage that
//   reads and writes the offset registers in the same cycle.
//   The receiver cannot stall; each result is valid for exactly one cycle.
//   A write on i_cfg_we sets the buffer size (0 acts as 1, above MAX_SIZE acts
//   as MAX_SIZE), empties the buffer and clears the mark. Write it only while
//   no request is in flight.
//   Reset (i_rst_n low, synchronous) empties the buffer, clears the mark and
//   sets the size to 4096, or to MAX_SIZE if that is smaller.
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_pointer_tracker_with_mark
    import rbpt_pkg::*;
#(
    parameter int unsigned MAX_SIZE = RBPT_MAX_SIZE,
    localparam int unsigned IDX_W = $clog2(MAX_SIZE),
    localparam int unsigned CNT_W = $clog2(MAX_SIZE + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_data,
    // request
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [2:0]       i_operation,
    input  wire logic [CNT_W-1:0] i_byte_count,
    // result
    output logic                  o_done,
    output logic [CNT_W-1:0]      o_free_total,
    output logic [CNT_W-1:0]      o_free_run,
    output logic [CNT_W-1:0]      o_ready_total,
    output logic [CNT_W-1:0]      o_ready_run,
    output logic                  o_at_mark,
    output logic [IDX_W-1:0]      o_write_offset,
    output logic [IDX_W-1:0]      o_read_offset,
    output logic                  o_rejected
);

    localparam logic [CNT_W-1:0] SIZE_MAX   = CNT_W'(MAX_SIZE);
    localparam logic [CNT_W-1:0] SIZE_RESET =
        CNT_W'((RBPT_RESET_SIZE < MAX_SIZE) ? RBPT_RESET_SIZE : MAX_SIZE);

    // forward distance from b to a, modulo size
    function automatic logic [CNT_W-1:0] f_dist(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b,
                                                input logic [CNT_W-1:0] size);
        if (a >= b) begin
            return CNT_W'(a) - CNT_W'(b);
        end
        return CNT_W'(a) + size - CNT_W'(b);
    endfunction

    // step an offset forward by c, wrapping at size (used only where c does not exceed size)
    function automatic logic [IDX_W-1:0] f_advance(input logic [IDX_W-1:0] a,
                                                   input logic [CNT_W-1:0] c,
                                                   input logic [CNT_W-1:0] size);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(c);
        if (s < {1'b0, size}) begin
            return IDX_W'(s);
        end
        return IDX_W'(s - {1'b0, size});
    endfunction

    // bytes held between read and write offsets
    function automatic logic [CNT_W-1:0] f_stored(input logic [IDX_W-1:0] w,
                                                  input logic [IDX_W-1:0] r,
                                                  input logic             full,
                                                  input logic [CNT_W-1:0] size);
        if (w == r) begin
            return full ? size : '0;
        end
        return f_dist(w, r, size);
    endfunction

    // state
    logic [CNT_W-1:0] r_size;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_mark_idx, n_mark_idx;
    logic             r_mark_vld, n_mark_vld;
    logic             r_full, n_full;

    // request register
    logic             r_req_vld;
    logic [2:0]       r_op;
    logic [CNT_W-1:0] r_cnt;

    // result register
    logic             r_done;
    logic [CNT_W-1:0] r_free_total, n_free_total;
    logic [CNT_W-1:0] r_free_run, n_free_run;
    logic [CNT_W-1:0] r_ready_total, n_ready_total;
    logic [CNT_W-1:0] r_ready_run, n_ready_run;
    logic             r_at_mark, n_at_mark;
    logic             r_rejected, n_rejected;

    logic [CNT_W-1:0] cur_stored;
    logic [CNT_W-1:0] new_used;
    logic [IDX_W-1:0] adv_idx;
    logic             new_empty;
    logic [CNT_W-1:0] cfg_size;

    assign busy = 1'b0;

    // clamp a written size into 1..MAX_SIZE
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_size = CNT_W'(1);
        end else if (i_cfg_data > SIZE_MAX) begin
            cfg_size = SIZE_MAX;
        end else begin
            cfg_size = i_cfg_data;
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
        r_op  <= i_operation;
        r_cnt <= i_byte_count;
    end

    // next offsets and mark for the registered request
    always_comb begin
        n_wr_idx   = r_wr_idx;
        n_rd_idx   = r_rd_idx;
        n_mark_idx = r_mark_idx;
        n_mark_vld = r_mark_vld;
        n_full     = r_full;
        n_rejected = 1'b0;
        cur_stored = f_stored(r_wr_idx, r_rd_idx, r_full, r_size);
        adv_idx    = '0;
        case (r_op)
            OP_SUPPLY: begin
                adv_idx = f_advance(r_wr_idx, r_cnt, r_size);
                if (r_cnt > r_size - cur_stored) begin
                    n_rejected = 1'b1;
                end else if (r_cnt != '0) begin
                    n_wr_idx = adv_idx;
                    n_full   = (adv_idx == r_rd_idx);
                end
            end
            OP_CONSUME: begin
                adv_idx = f_advance(r_rd_idx, r_cnt, r_size);
                if (r_cnt > cur_stored) begin
                    n_rejected = 1'b1;
                end else if (r_cnt != '0) begin
                    // passing the mark drops it
                    if (r_mark_vld && (f_dist(r_mark_idx, r_rd_idx, r_size) < r_cnt)) begin
                        n_mark_vld = 1'b0;
                        n_mark_idx = '0;
                    end
                    n_full = 1'b0;
                    if (adv_idx == r_wr_idx) begin
                        n_wr_idx = '0;
                        n_rd_idx = '0;
                    end else begin
                        n_rd_idx = adv_idx;
                    end
                end
            end
            OP_SET_MARK: begin
                // mark the last supplied byte; nothing to mark when empty
                if (r_wr_idx != r_rd_idx || r_full) begin
                    n_mark_idx = (r_wr_idx == '0) ? IDX_W'(r_size - CNT_W'(1))
                                                  : r_wr_idx - IDX_W'(1);
                    n_mark_vld = 1'b1;
                end
            end
            OP_CLEAR_MARK: begin
                n_mark_vld = 1'b0;
                n_mark_idx = '0;
            end
            default: begin
            end
        endcase
    end

    // report fields from the updated state
    always_comb begin
        new_used     = f_stored(n_wr_idx, n_rd_idx, n_full, r_size);
        new_empty    = (n_wr_idx == n_rd_idx) && !n_full;
        n_free_total = r_size - new_used;
        if (n_rd_idx < n_wr_idx || new_empty) begin
            n_free_run = r_size - CNT_W'(n_wr_idx);
        end else if (n_full) begin
            n_free_run = '0;
        end else begin
            n_free_run = f_dist(n_rd_idx, n_wr_idx, r_size);
        end

        n_at_mark = n_mark_vld && (n_mark_idx == n_rd_idx);
        if (!n_mark_vld || n_at_mark) begin
            n_ready_total = new_used;
            if (n_wr_idx < n_rd_idx || (n_wr_idx == n_rd_idx && n_full)) begin
                n_ready_run = r_size - CNT_W'(n_rd_idx);
            end else begin
                n_ready_run = CNT_W'(n_wr_idx) - CNT_W'(n_rd_idx);
            end
        end else begin
            n_ready_total = f_dist(n_mark_idx, n_rd_idx, r_size);
            if (n_mark_idx < n_rd_idx) begin
                n_ready_run = r_size - CNT_W'(n_rd_idx);
            end else begin
                n_ready_run = CNT_W'(n_mark_idx) - CNT_W'(n_rd_idx);
            end
        end
    end

    // tracker state: a size write empties the buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= SIZE_RESET;
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_mark_idx <= '0;
            r_mark_vld <= 1'b0;
            r_full     <= 1'b0;
        end else if (i_cfg_we) begin
            r_size     <= cfg_size;
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_mark_idx <= '0;
            r_mark_vld <= 1'b0;
            r_full     <= 1'b0;
        end else if (r_req_vld) begin
            r_wr_idx   <= n_wr_idx;
            r_rd_idx   <= n_rd_idx;
            r_mark_idx <= n_mark_idx;
            r_mark_vld <= n_mark_vld;
            r_full     <= n_full;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_req_vld;
        end
        r_free_total   <= n_free_total;
        r_free_run     <= n_free_run;
        r_ready_total  <= n_ready_total;
        r_ready_run    <= n_ready_run;
        r_at_mark      <= n_at_mark;
        r_rejected     <= n_rejected;
    end

    assign o_done         = r_done;
    assign o_free_total   = r_free_total;
    assign o_free_run     = r_free_run;
    assign o_ready_total  = r_ready_total;
    assign o_ready_run    = r_ready_run;
    assign o_at_mark      = r_at_mark;
    assign o_write_offset = r_wr_idx;
    assign o_read_offset  = r_rd_idx;
    assign o_rejected     = r_rejected;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the ring buffer pointer tracker with urgent mark.
`timescale 1ns / 1ps

module testbench;
    import rbpt_pkg::*;

    localparam logic [12:0] SIZE_MAX     = 13'(RBPT_MAX_SIZE);
    localparam int unsigned PIPE_LATENCY = 2;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam logic [2:0]  OP_LAST_CODE = 3'd7;
    localparam logic [12:0] COUNT_ALL    = 13'h1FFF;

    // One status report of the tracker
    typedef struct {
        int unsigned free_total;
        int unsigned free_run;
        int unsigned ready_total;
        int unsigned ready_run;
        bit          at_mark;
        int unsigned write_offset;
        int unsigned read_offset;
        bit          rejected;
    } t_status;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [12:0] cfg_data;
    logic        start;
    logic        busy;
    logic [2:0]  op_drv;
    logic [12:0] cnt_drv;
    logic        o_done;
    logic [12:0] o_free_total;
    logic [12:0] o_free_run;
    logic [12:0] o_ready_total;
    logic [12:0] o_ready_run;
    logic        o_at_mark;
    logic [11:0] o_write_offset;
    logic [11:0] o_read_offset;
    logic        o_rejected;

    // Shadow copy of the tracker state
    int unsigned ring_bytes;
    int unsigned wr_pos;
    int unsigned rd_pos;
    int unsigned mark_pos;
    bit          mark_set;
    bit          is_full;

    t_status     status_q[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          burst_mode  = 1'b0;

    ring_buffer_pointer_tracker_with_mark i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .start          (start),
        .busy           (busy),
        .i_operation    (op_drv),
        .i_byte_count   (cnt_drv),
        .o_done         (o_done),
        .o_free_total   (o_free_total),
        .o_free_run     (o_free_run),
        .o_ready_total  (o_ready_total),
        .o_ready_run    (o_ready_run),
        .o_at_mark      (o_at_mark),
        .o_write_offset (o_write_offset),
        .o_read_offset  (o_read_offset),
        .o_rejected     (o_rejected)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Status predictor
    // ---------------------------------------------------------------

    // forward distance from b to a around the ring
    function automatic int unsigned gap_fwd(int unsigned a, int unsigned b);
        return (a >= b) ? (a - b) : (a + ring_bytes - b);
    endfunction

    function automatic int unsigned step_fwd(int unsigned a, int unsigned c);
        return (a + c < ring_bytes) ? (a + c) : (a + c - ring_bytes);
    endfunction

    function automatic bit shadow_drained();
        return (wr_pos == rd_pos) && !is_full;
    endfunction

    function automatic int unsigned bytes_held();
        if (wr_pos == rd_pos)
            return is_full ? ring_bytes : 0;
        return gap_fwd(wr_pos, rd_pos);
    endfunction

    // Size write: clamp, then empty the ring and drop the mark
    function automatic void load_size(logic [12:0] v);
        if (v == 0)
            ring_bytes = 1;
        else if (v > SIZE_MAX)
            ring_bytes = SIZE_MAX;
        else
            ring_bytes = v;
        wr_pos   = 0;
        rd_pos   = 0;
        mark_pos = 0;
        mark_set = 1'b0;
        is_full  = 1'b0;
    endfunction

    // Applies one request to the shadow state and returns the status it reports
    function automatic t_status apply_request(logic [2:0] op, logic [12:0] cnt);
        t_status     r;
        int unsigned used;
        bit          here;
        r.rejected = 1'b0;
        case (op)
            OP_SUPPLY: begin
                if (cnt > ring_bytes - bytes_held()) begin
                    r.rejected = 1'b1;
                end else if (cnt != 0) begin
                    wr_pos  = step_fwd(wr_pos, cnt);
                    is_full = (wr_pos == rd_pos);
                end
            end
            OP_CONSUME: begin
                if (cnt > bytes_held()) begin
                    r.rejected = 1'b1;
                end else if (cnt != 0) begin
                    // passing the mark drops it
                    if (mark_set && gap_fwd(mark_pos, rd_pos) < cnt) begin
                        mark_set = 1'b0;
                        mark_pos = 0;
                    end
                    rd_pos  = step_fwd(rd_pos, cnt);
                    is_full = 1'b0;
                    if (wr_pos == rd_pos) begin
                        wr_pos = 0;
                        rd_pos = 0;
                    end
                end
            end
            OP_SET_MARK: begin
                if (!shadow_drained()) begin
                    mark_pos = (wr_pos == 0) ? ring_bytes - 1 : wr_pos - 1;
                    mark_set = 1'b1;
                end
            end
            OP_CLEAR_MARK: begin
                mark_set = 1'b0;
                mark_pos = 0;
            end
            default: ;
        endcase

        used         = bytes_held();
        r.free_total = ring_bytes - used;
        if (rd_pos < wr_pos || shadow_drained())
            r.free_run = ring_bytes - wr_pos;
        else
            r.free_run = is_full ? 0 : gap_fwd(rd_pos, wr_pos);

        // readable values stop at the mark unless the read offset sits on it
        here = mark_set && (mark_pos == rd_pos);
        if (!mark_set || here) begin
            r.ready_total = used;
            if (wr_pos < rd_pos || (wr_pos == rd_pos && is_full))
                r.ready_run = ring_bytes - rd_pos;
            else
                r.ready_run = wr_pos - rd_pos;
        end else begin
            r.ready_total = gap_fwd(mark_pos, rd_pos);
            r.ready_run   = (mark_pos < rd_pos) ? ring_bytes - rd_pos : mark_pos - rd_pos;
        end
        r.at_mark      = here;
        r.write_offset = wr_pos;
        r.read_offset  = rd_pos;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------

    function automatic void check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        end
    endfunction

    always @(posedge i_clk) begin
        t_status exp;
        if (i_rst_n && o_done) begin
            if (status_q.size() == 0) begin
                error_count++;
                $display("%0t: result with no request pending, expected none, actual done=1",
                         $time);
            end else begin
                exp = status_q.pop_front();
                check_field("free_total", exp.free_total, o_free_total);
                check_field("free_run", exp.free_run, o_free_run);
                check_field("ready_total", exp.ready_total, o_ready_total);
                check_field("ready_run", exp.ready_run, o_ready_run);
                check_field("at_mark", exp.at_mark, o_at_mark);
                check_field("write_offset", exp.write_offset, o_write_offset);
                check_field("read_offset", exp.read_offset, o_read_offset);
                check_field("rejected", exp.rejected, o_rejected);
            end
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Issue one request after a random idle gap (none in burst mode), predict once it is taken
    task automatic send_request(input logic [2:0] op, input logic [12:0] cnt);
        int unsigned idle_cycles;
        idle_cycles = burst_mode ? 0 : $urandom_range(0, 11);
        repeat (idle_cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start   <= 1'b1;
        op_drv  <= op;
        cnt_drv <= cnt;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        status_q.push_back(apply_request(op, cnt));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (status_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [12:0] v);
        wait_idle();
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        load_size(v);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Default state after reset, plus undefined codes acting as a query
    task automatic test_reset_state();
        logic [2:0] op;
        send_request(OP_QUERY, COUNT_ALL);
        for (op = OP_QUERY + 3'd1; op != 3'd0; op++)
            send_request(op, 13'd0);
    endtask

    // Zero counts, filling to full, oversize rejects, emptying
    task automatic test_supply_consume();
        send_request(OP_SUPPLY, 13'd0);
        send_request(OP_CONSUME, 13'd0);
        send_request(OP_SUPPLY, SIZE_MAX);
        send_request(OP_SUPPLY, 13'd1);
        send_request(OP_CONSUME, SIZE_MAX + 13'd1);
        send_request(OP_CONSUME, SIZE_MAX);
        send_request(OP_SUPPLY, COUNT_ALL);
    endtask

    // Mark set, kept, passed, ignored on empty, wrapped at offset zero, cleared
    task automatic test_mark();
        write_size(13'd16);
        send_request(OP_SUPPLY, 13'd10);
        send_request(OP_SET_MARK, 13'd0);
        send_request(OP_CONSUME, 13'd3);
        send_request(OP_CONSUME, 13'd7);
        send_request(OP_SET_MARK, 13'd0);
        send_request(OP_SUPPLY, 13'd16);
        send_request(OP_SET_MARK, 13'd0);
        send_request(OP_CLEAR_MARK, COUNT_ALL);
    endtask

    // Size register below and above its usable range
    task automatic test_size_extremes();
        write_size(13'd0);
        send_request(OP_SUPPLY, 13'd1);
        send_request(OP_SET_MARK, 13'd0);
        send_request(OP_CONSUME, 13'd1);
        write_size(COUNT_ALL);
        send_request(OP_QUERY, 13'd0);
    endtask

    // Mostly legal traffic with random counts, some oversize and noise requests
    task automatic run_random_phase(input logic [12:0] size, input int unsigned n);
        int unsigned pick;
        int unsigned room;
        int unsigned held;
        logic [12:0] cnt;
        write_size(size);
        for (int unsigned i = 0; i < n; i++) begin
            if (i % 40 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            held = bytes_held();
            room = ring_bytes - held;
            if (pick < 40) begin
                case ($urandom_range(0, 9))
                    0: cnt = 13'd0;
                    1: cnt = 13'(room);
                    2: cnt = 13'($urandom_range(room + 1, COUNT_ALL));
                    default: cnt = (room == 0) ? 13'd0 : 13'($urandom_range(1, room));
                endcase
                send_request(OP_SUPPLY, cnt);
            end else if (pick < 70) begin
                case ($urandom_range(0, 9))
                    0: cnt = 13'd0;
                    1: cnt = 13'(held);
                    2: cnt = 13'($urandom_range(held + 1, COUNT_ALL));
                    default: cnt = (held == 0) ? 13'd0 : 13'($urandom_range(1, held));
                endcase
                send_request(OP_CONSUME, cnt);
            end else if (pick < 80) begin
                send_request(OP_SET_MARK, 13'($urandom_range(0, COUNT_ALL)));
            end else if (pick < 85) begin
                send_request(OP_CLEAR_MARK, 13'($urandom_range(0, COUNT_ALL)));
            end else if (pick < 90) begin
                send_request(3'($urandom_range(OP_QUERY, OP_LAST_CODE)),
                             13'($urandom_range(0, COUNT_ALL)));
            end else begin
                send_request(3'($urandom_range(0, OP_LAST_CODE)),
                             13'($urandom_range(0, COUNT_ALL)));
            end
        end
    endtask

    task automatic test_random();
        run_random_phase(SIZE_MAX, 72);
        run_random_phase(13'd1, 72);
        run_random_phase(13'd0, 72);
        run_random_phase(13'd2, 72);
        run_random_phase(13'd3, 72);
        run_random_phase(13'd16, 72);
        run_random_phase(13'd100, 72);
        run_random_phase(COUNT_ALL, 72);
        run_random_phase(SIZE_MAX + 13'd1, 72);
        run_random_phase(13'($urandom_range(1, SIZE_MAX)), 72);
        run_random_phase(13'd255, 72);
        run_random_phase(SIZE_MAX, 72);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        start    = 1'b0;
        op_drv   = OP_QUERY;
        cnt_drv  = '0;
        load_size(13'(RBPT_RESET_SIZE));
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_supply_consume();
        test_mark();
        test_size_extremes();
        test_random();

        wait_idle();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (status_q.size() != 0) begin
            error_count++;
            $display("%0t: results missing, expected 0 pending, actual %0d",
                     $time, status_q.size());
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
sv/rbpt_pkg.sv
sv/ring_buffer_pointer_tracker_with_mark.sv
sim/testbench.sv
